/* design/mpg_pkg.sv */
// ----------------------------------------------------------------------------
// Mouse packet generator package
// Opcodes, packet constants and default parameters shared by the design
// and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package mpg_pkg;

    // Event opcodes
    localparam logic [2:0] OP_INIT     = 3'd0;
    localparam logic [2:0] OP_ADD_MOVE = 3'd1;
    localparam logic [2:0] OP_SET_POS  = 3'd2;
    localparam logic [2:0] OP_SET_BTN  = 3'd3;
    localparam logic [2:0] OP_REQ_PKT  = 3'd4;

    // Button indexes
    localparam logic [1:0] BTN_LEFT  = 2'd0;
    localparam logic [1:0] BTN_RIGHT = 2'd1;

    // Header is 0xF8 with the left button in bit 1 and the right in bit 0.
    localparam logic [5:0] HEADER_TOP = 6'b111110;

    localparam int STEP_MAX = 127;

    localparam int FRAC_BITS_DEF = 8;

endpackage : mpg_pkg

`default_nettype wire

/* design/mouse_packet_generator.sv */
// ----------------------------------------------------------------------------
// Mouse packet generator
// Relative mouse packet encoder with button tracking, motion accumulation
// and absolute position chasing.
// ----------------------------------------------------------------------------
// Usage:
//   Events enter on the input channel (i_in_valid / o_in_ready) and each one
//   gives exactly one result on the output channel (o_out_valid /
//   i_out_ready). A result carries the update-pending flag and, for a packet
//   request that has something to send, a three-byte packet.
//   An accepted request is held in an input register; when the result
//   register is empty or being taken, the event logic updates the state and
//   loads the result register, so a request passes through the input register
//   and then the result register. One request is taken every cycle while
//   results are taken; the rate is set by the single input-to-result stage,
//   which also updates all state. When the receiver stalls, the result
//   register holds its result and the input register holds the next request;
//   ready drops only when both are full. Reset clears all state, the mode
//   register and both stages. The user must write the relative_mode register
//   through i_cfg_we / i_cfg_wdata while no request is in flight; not enforced.
// ----------------------------------------------------------------------------
`default_nettype none

module mouse_packet_generator #(
    parameter int FRAC_BITS = mpg_pkg::FRAC_BITS_DEF
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    // Configuration
    input  wire                i_cfg_we,
    input  wire                i_cfg_wdata,
    // Event channel
    input  wire                i_in_valid,
    output logic               o_in_ready,
    input  wire         [2:0]  i_opcode,
    input  wire  signed [23:0] i_move_x,
    input  wire  signed [23:0] i_move_y,
    input  wire         [15:0] i_pos_x,
    input  wire         [15:0] i_pos_y,
    input  wire         [15:0] i_target_cur_x,
    input  wire         [15:0] i_target_cur_y,
    input  wire         [1:0]  i_button_index,
    input  wire                i_button_down,
    // Result channel
    output logic               o_out_valid,
    input  wire                i_out_ready,
    output logic               o_update_pending,
    output logic               o_packet_valid,
    output logic        [7:0]  o_packet_header,
    output logic signed [7:0]  o_packet_dx,
    output logic signed [7:0]  o_packet_dy
);

    localparam logic signed [32:0] ROUND_NEG = 33'((64'd1 << FRAC_BITS) - 64'd1);
    localparam logic signed [32:0] STEP_POS  = 33'(mpg_pkg::STEP_MAX);
    localparam logic signed [32:0] STEP_NEG  = -33'(mpg_pkg::STEP_MAX);

    // Input register
    logic               r_in_valid;
    logic        [2:0]  r_opcode;
    logic signed [23:0] r_move_x;
    logic signed [23:0] r_move_y;
    logic        [15:0] r_pos_x;
    logic        [15:0] r_pos_y;
    logic        [15:0] r_target_cur_x;
    logic        [15:0] r_target_cur_y;
    logic        [1:0]  r_button_index;
    logic               r_button_down;

    // Block state
    logic               r_relative_mode;
    logic               r_initialised;
    logic        [15:0] r_target_x, n_target_x;
    logic        [15:0] r_target_y, n_target_y;
    logic        [15:0] r_wanted_x, n_wanted_x;
    logic        [15:0] r_wanted_y, n_wanted_y;
    logic signed [31:0] r_acc_x, n_acc_x;
    logic signed [31:0] r_acc_y, n_acc_y;
    logic        [1:0]  r_host_btn, n_host_btn;
    logic        [1:0]  r_sent_btn, n_sent_btn;
    logic               n_initialised;

    // Result register
    logic               r_out_valid;
    logic               r_pending, n_pending;
    logic               r_pkt_valid, n_pkt_valid;
    logic        [7:0]  r_header, n_header;
    logic signed [7:0]  r_dx, n_dx;
    logic signed [7:0]  r_dy, n_dy;

    logic               w_advance;

    // Integer part of an accumulator, truncated toward zero.
    function automatic logic signed [32:0] f_int_part(input logic signed [31:0] acc);
        logic signed [32:0] v;
        v = {acc[31], acc};
        if (acc[31]) begin
            v = v + ROUND_NEG;
        end
        return v >>> FRAC_BITS;
    endfunction

    function automatic logic signed [7:0] f_clamp(input logic signed [32:0] d);
        logic signed [7:0] s;
        if (d > STEP_POS) begin
            s = STEP_POS[7:0];
        end else if (d < STEP_NEG) begin
            s = STEP_NEG[7:0];
        end else begin
            s = d[7:0];
        end
        return s;
    endfunction

    function automatic logic signed [31:0] f_sat_add(input logic signed [31:0] acc,
                                                     input logic signed [23:0] mv);
        logic signed [32:0] sum;
        logic signed [31:0] res;
        sum = {acc[31], acc} + {{9{mv[23]}}, mv};
        if (sum[32] != sum[31]) begin
            res = sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            res = sum[31:0];
        end
        return res;
    endfunction

    assign w_advance  = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = i_rst_n && (!r_in_valid || w_advance);

    // Event logic
    always_comb begin
        logic signed [32:0] ip_x;
        logic signed [32:0] ip_y;
        logic signed [32:0] dist_x;
        logic signed [32:0] dist_y;
        logic signed [32:0] step_x;
        logic signed [32:0] step_y;
        logic signed [7:0]  cx;
        logic signed [7:0]  cy;
        logic        [1:0]  bit_mask;

        n_initialised = r_initialised;
        n_target_x    = r_target_x;
        n_target_y    = r_target_y;
        n_wanted_x    = r_wanted_x;
        n_wanted_y    = r_wanted_y;
        n_acc_x       = r_acc_x;
        n_acc_y       = r_acc_y;
        n_host_btn    = r_host_btn;
        n_sent_btn    = r_sent_btn;
        n_pending     = 1'b0;
        n_pkt_valid   = 1'b0;
        n_header      = 8'd0;
        n_dx          = 8'sd0;
        n_dy          = 8'sd0;

        ip_x     = f_int_part(r_acc_x);
        ip_y     = f_int_part(r_acc_y);
        dist_x   = 33'(signed'({1'b0, r_wanted_x})) - 33'(signed'({1'b0, r_target_x}));
        dist_y   = 33'(signed'({1'b0, r_wanted_y})) - 33'(signed'({1'b0, r_target_y}));
        step_x   = r_relative_mode ? ip_x : dist_x;
        step_y   = r_relative_mode ? ip_y : dist_y;
        cx       = f_clamp(step_x);
        cy       = f_clamp(step_y);
        bit_mask = (r_button_index == mpg_pkg::BTN_LEFT) ? 2'b01 : 2'b10;

        case (r_opcode)
            mpg_pkg::OP_INIT: begin
                n_initialised = 1'b1;
                n_host_btn    = 2'b00;
                n_sent_btn    = 2'b00;
                n_target_x    = r_pos_x;
                n_target_y    = r_pos_y;
            end
            mpg_pkg::OP_ADD_MOVE: begin
                if (r_initialised) begin
                    n_acc_x   = f_sat_add(r_acc_x, r_move_x);
                    n_acc_y   = f_sat_add(r_acc_y, r_move_y);
                    n_pending = (f_int_part(n_acc_x) != 33'sd0) ||
                                (f_int_part(n_acc_y) != 33'sd0);
                end
            end
            mpg_pkg::OP_SET_POS: begin
                if (r_initialised) begin
                    n_wanted_x = r_pos_x;
                    n_wanted_y = r_pos_y;
                    n_target_x = r_target_cur_x;
                    n_target_y = r_target_cur_y;
                    n_pending  = (r_pos_x != r_target_cur_x) || (r_pos_y != r_target_cur_y);
                end
            end
            mpg_pkg::OP_SET_BTN: begin
                if (r_button_index == mpg_pkg::BTN_LEFT ||
                    r_button_index == mpg_pkg::BTN_RIGHT) begin
                    n_host_btn = r_button_down ? (r_host_btn | bit_mask)
                                               : (r_host_btn & ~bit_mask);
                    n_pending  = |((n_host_btn ^ r_sent_btn) & bit_mask);
                end
            end
            mpg_pkg::OP_REQ_PKT: begin
                if (step_x != 33'sd0 || step_y != 33'sd0 || r_host_btn != r_sent_btn) begin
                    n_pending   = 1'b1;
                    n_pkt_valid = 1'b1;
                    n_header    = {mpg_pkg::HEADER_TOP, r_host_btn[0], r_host_btn[1]};
                    n_sent_btn  = r_host_btn;
                    n_dx        = cx;
                    n_dy        = cy;
                    if (r_relative_mode) begin
                        // The sent step is never larger than the integer part,
                        // so the accumulator only shrinks here.
                        n_acc_x = r_acc_x - (32'(cx) <<< FRAC_BITS);
                        n_acc_y = r_acc_y - (32'(cy) <<< FRAC_BITS);
                    end else begin
                        n_target_x = r_target_x + 16'(cx);
                        n_target_y = r_target_y + 16'(cy);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid      <= 1'b0;
            r_out_valid     <= 1'b0;
            r_relative_mode <= 1'b0;
            r_initialised   <= 1'b0;
            r_target_x      <= '0;
            r_target_y      <= '0;
            r_wanted_x      <= '0;
            r_wanted_y      <= '0;
            r_acc_x         <= '0;
            r_acc_y         <= '0;
            r_host_btn      <= '0;
            r_sent_btn      <= '0;
        end else begin
            if (i_cfg_we) begin
                r_relative_mode <= i_cfg_wdata;
            end
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_advance) begin
                r_out_valid   <= 1'b1;
                r_initialised <= n_initialised;
                r_target_x    <= n_target_x;
                r_target_y    <= n_target_y;
                r_wanted_x    <= n_wanted_x;
                r_wanted_y    <= n_wanted_y;
                r_acc_x       <= n_acc_x;
                r_acc_y       <= n_acc_y;
                r_host_btn    <= n_host_btn;
                r_sent_btn    <= n_sent_btn;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_opcode       <= i_opcode;
            r_move_x       <= i_move_x;
            r_move_y       <= i_move_y;
            r_pos_x        <= i_pos_x;
            r_pos_y        <= i_pos_y;
            r_target_cur_x <= i_target_cur_x;
            r_target_cur_y <= i_target_cur_y;
            r_button_index <= i_button_index;
            r_button_down  <= i_button_down;
        end
        if (w_advance) begin
            r_pending   <= n_pending;
            r_pkt_valid <= n_pkt_valid;
            r_header    <= n_header;
            r_dx        <= n_dx;
            r_dy        <= n_dy;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_update_pending = r_pending;
    assign o_packet_valid   = r_pkt_valid;
    assign o_packet_header  = r_header;
    assign o_packet_dx      = r_dx;
    assign o_packet_dy      = r_dy;

endmodule : mouse_packet_generator

`default_nettype wire

/* design/mpg_checker.sv */
// ----------------------------------------------------------------------------
// Mouse packet generator checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mpg_checker (
    input wire              i_clk,
    input wire              i_rst_n,
    input wire              o_out_valid,
    input wire              i_out_ready,
    input wire              o_update_pending,
    input wire              o_packet_valid,
    input wire        [7:0] o_packet_header,
    input wire signed [7:0] o_packet_dx,
    input wire signed [7:0] o_packet_dy
);

    // A stalled result keeps its contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_packet_header) &&
            $stable(o_packet_dx) && $stable(o_packet_dy) && $stable(o_update_pending))
        else $error("result changed while stalled");

    // A packet always reports a pending update.
    a_pkt_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_packet_valid |-> o_update_pending)
        else $error("packet without pending update");

    // Outside a packet the packet bytes are zero.
    a_no_pkt_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_packet_valid |->
            o_packet_header == 8'd0 && o_packet_dx == 8'sd0 && o_packet_dy == 8'sd0)
        else $error("packet bytes set without a packet");

    // A packet has a proper header and steps within the clamp.
    a_pkt_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_packet_valid |->
            o_packet_header[7:2] == mpg_pkg::HEADER_TOP &&
            o_packet_dx != -8'sd128 && o_packet_dy != -8'sd128)
        else $error("malformed packet");

    // No result is shown right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule : mpg_checker

bind mouse_packet_generator mpg_checker u_mpg_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_update_pending (o_update_pending),
    .o_packet_valid   (o_packet_valid),
    .o_packet_header  (o_packet_header),
    .o_packet_dx      (o_packet_dx),
    .o_packet_dy      (o_packet_dy)
);

`default_nettype wire

/* tb/mouse_packet_generator_tb.sv */
// ----------------------------------------------------------------------------
// Mouse packet generator testbench
// Drives mouse events through the valid/ready request channel and checks
// every reply against a cycle-free model of the encoder. The model covers
// button tracking, saturating 24.8 motion accumulation, absolute chasing and
// the 0xF8 packet header. A directed pass comes first, then random traffic
// in both modes, with bursty senders, a stalling receiver and long
// receiver hold-offs that back the block up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mouse_packet_generator_tb;

    localparam int     FRAC        = mpg_pkg::FRAC_BITS_DEF;
    localparam longint STEP_UNIT   = longint'(1) << FRAC;
    localparam longint ACC_MAX     = 64'sd2147483647;
    localparam longint ACC_MIN     = -64'sd2147483648;
    localparam int     HOLD_CYCLES = 120;
    localparam int     CYCLE_LIMIT = 500000;

    // Opcodes past the request opcode do nothing.
    localparam logic [2:0] OP_UNUSED_LO = 3'd5;
    localparam logic [2:0] OP_UNUSED_HI = 3'd7;
    // Button indexes that the block ignores.
    localparam logic [1:0] BTN_SPARE_A = 2'd2;
    localparam logic [1:0] BTN_SPARE_B = 2'd3;

    typedef struct packed {
        logic [2:0]         opcode;
        logic signed [23:0] move_x;
        logic signed [23:0] move_y;
        logic [15:0]        pos_x;
        logic [15:0]        pos_y;
        logic [15:0]        tcur_x;
        logic [15:0]        tcur_y;
        logic [1:0]         btn_idx;
        logic               btn_down;
    } t_mouse_event;

    typedef struct packed {
        logic [2:0] opcode;
        logic       pending;
        logic       valid;
        logic [7:0] header;
        logic [7:0] dx;
        logic [7:0] dy;
    } t_mouse_reply;

    logic               i_clk          = 1'b0;
    logic               i_rst_n        = 1'b0;
    logic               i_cfg_we       = 1'b0;
    logic               i_cfg_wdata    = 1'b0;
    logic               i_in_valid     = 1'b0;
    logic [2:0]         i_opcode       = '0;
    logic signed [23:0] i_move_x       = '0;
    logic signed [23:0] i_move_y       = '0;
    logic [15:0]        i_pos_x        = '0;
    logic [15:0]        i_pos_y        = '0;
    logic [15:0]        i_target_cur_x = '0;
    logic [15:0]        i_target_cur_y = '0;
    logic [1:0]         i_button_index = '0;
    logic               i_button_down  = 1'b0;
    logic               i_out_ready    = 1'b0;

    wire                o_in_ready;
    wire                o_out_valid;
    wire                o_update_pending;
    wire                o_packet_valid;
    wire [7:0]          o_packet_header;
    wire signed [7:0]   o_packet_dx;
    wire signed [7:0]   o_packet_dy;

    mouse_packet_generator dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_opcode         (i_opcode),
        .i_move_x         (i_move_x),
        .i_move_y         (i_move_y),
        .i_pos_x          (i_pos_x),
        .i_pos_y          (i_pos_y),
        .i_target_cur_x   (i_target_cur_x),
        .i_target_cur_y   (i_target_cur_y),
        .i_button_index   (i_button_index),
        .i_button_down    (i_button_down),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_update_pending (o_update_pending),
        .o_packet_valid   (o_packet_valid),
        .o_packet_header  (o_packet_header),
        .o_packet_dx      (o_packet_dx),
        .o_packet_dy      (o_packet_dy)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Encoder state as the testbench tracks it.
    bit          rel_mode = 1'b0;
    bit          inited   = 1'b0;
    logic [15:0] trk_x    = '0;
    logic [15:0] trk_y    = '0;
    logic [15:0] host_x   = '0;
    logic [15:0] host_y   = '0;
    longint      acc_x    = 0;
    longint      acc_y    = 0;
    logic [1:0]  host_btn = '0;
    logic [1:0]  sent_btn = '0;

    t_mouse_reply reply_q[$];

    int  errors      = 0;
    int  n_sent      = 0;
    int  n_replies   = 0;
    int  n_packets   = 0;
    int  burst_left  = 0;
    int  cycle_count = 0;
    int  stall_mode  = 0;
    int  stall_left  = 0;
    bit  hold_go     = 1'b0;
    logic hold_active = 1'b0;

    function automatic longint whole_pixels(input longint acc);
        if (acc >= 0)
            return acc >>> FRAC;
        return -((-acc) >>> FRAC);
    endfunction

    function automatic longint clip_acc(input longint v);
        if (v > ACC_MAX)
            return ACC_MAX;
        if (v < ACC_MIN)
            return ACC_MIN;
        return v;
    endfunction

    function automatic longint clamp_step(input longint d);
        if (d > mpg_pkg::STEP_MAX)
            return mpg_pkg::STEP_MAX;
        if (d < -mpg_pkg::STEP_MAX)
            return -mpg_pkg::STEP_MAX;
        return d;
    endfunction

    // Applies one accepted request to the tracked state and queues its reply.
    function automatic void encode_event(input t_mouse_event ev);
        t_mouse_reply r;
        longint       xd;
        longint       yd;
        longint       sx;
        longint       sy;
        logic [1:0]   bmask;
        r = '0;
        r.opcode = ev.opcode;
        case (ev.opcode)
            mpg_pkg::OP_INIT: begin
                inited   = 1'b1;
                host_btn = '0;
                sent_btn = '0;
                trk_x    = ev.pos_x;
                trk_y    = ev.pos_y;
            end
            mpg_pkg::OP_ADD_MOVE: begin
                if (inited) begin
                    acc_x = clip_acc(acc_x + longint'($signed(ev.move_x)));
                    acc_y = clip_acc(acc_y + longint'($signed(ev.move_y)));
                    r.pending = (whole_pixels(acc_x) != 0) || (whole_pixels(acc_y) != 0);
                end
            end
            mpg_pkg::OP_SET_POS: begin
                if (inited) begin
                    host_x = ev.pos_x;
                    host_y = ev.pos_y;
                    trk_x  = ev.tcur_x;
                    trk_y  = ev.tcur_y;
                    r.pending = (host_x != trk_x) || (host_y != trk_y);
                end
            end
            mpg_pkg::OP_SET_BTN: begin
                if (ev.btn_idx == mpg_pkg::BTN_LEFT || ev.btn_idx == mpg_pkg::BTN_RIGHT) begin
                    bmask = 2'b01 << ev.btn_idx;
                    if (ev.btn_down)
                        host_btn = host_btn | bmask;
                    else
                        host_btn = host_btn & ~bmask;
                    r.pending = |((host_btn ^ sent_btn) & bmask);
                end
            end
            mpg_pkg::OP_REQ_PKT: begin
                if (rel_mode) begin
                    xd = whole_pixels(acc_x);
                    yd = whole_pixels(acc_y);
                end else begin
                    xd = longint'(host_x) - longint'(trk_x);
                    yd = longint'(host_y) - longint'(trk_y);
                end
                if (xd != 0 || yd != 0 || host_btn != sent_btn) begin
                    sx = clamp_step(xd);
                    sy = clamp_step(yd);
                    r.pending = 1'b1;
                    r.valid   = 1'b1;
                    r.header  = {mpg_pkg::HEADER_TOP, host_btn[0], host_btn[1]};
                    r.dx      = 8'(sx);
                    r.dy      = 8'(sy);
                    sent_btn  = host_btn;
                    if (rel_mode) begin
                        acc_x = acc_x - sx * STEP_UNIT;
                        acc_y = acc_y - sy * STEP_UNIT;
                    end else begin
                        trk_x = 16'(longint'(trk_x) + sx);
                        trk_y = 16'(longint'(trk_y) + sy);
                    end
                end
            end
            default: ;
        endcase
        reply_q.push_back(r);
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("ERROR: reply %0d: %s is %0h, expected %0h", n_replies, what, got, want);
        errors++;
    endtask

    task automatic check_reply();
        t_mouse_reply e;
        if (reply_q.size() == 0) begin
            report("reply with no request behind it", 32'd1, 32'd0);
            return;
        end
        e = reply_q.pop_front();
        if (o_update_pending !== e.pending)
            report("update_pending", 32'(o_update_pending), 32'(e.pending));
        if (o_packet_valid !== e.valid)
            report("packet_valid", 32'(o_packet_valid), 32'(e.valid));
        if (o_packet_header !== e.header)
            report("packet_header", 32'(o_packet_header), 32'(e.header));
        if (o_packet_dx !== e.dx)
            report("packet_dx", 32'(o_packet_dx), 32'(e.dx));
        if (o_packet_dy !== e.dy)
            report("packet_dy", 32'(o_packet_dy), 32'(e.dy));
        if (e.valid)
            n_packets++;
        n_replies++;
    endtask

    // Receiver: checks each reply, then picks its ready for the next cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            check_reply();
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 2);
            stall_left <= $urandom_range(8, 60);
        end else begin
            stall_left <= stall_left - 1;
        end
        if (hold_active) begin
            i_out_ready <= 1'b0;
        end else begin
            case (stall_mode)
                0:       i_out_ready <= 1'b1;
                1:       i_out_ready <= 1'($urandom_range(0, 1));
                default: i_out_ready <= (stall_left % 4 == 0);
            endcase
        end
    end

    // Long receiver hold-off, counted here so the sender keeps pushing.
    always begin
        @(posedge hold_go);
        hold_active <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_active <= 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out with %0d replies outstanding", reply_q.size());
            $display("mouse_packet_generator: mismatch");
            $finish;
        end
    end

    function automatic logic signed [23:0] random_motion();
        if ($urandom_range(0, 7) == 0)
            return 24'($urandom);
        return 24'(int'($urandom_range(0, 4095)) - 2048);
    endfunction

    // Every field gets random content; callers override what matters.
    function automatic t_mouse_event make_event(input logic [2:0] op);
        t_mouse_event ev;
        ev.opcode   = op;
        ev.move_x   = random_motion();
        ev.move_y   = random_motion();
        ev.pos_x    = 16'($urandom);
        ev.pos_y    = 16'($urandom);
        ev.tcur_x   = 16'($urandom);
        ev.tcur_y   = 16'($urandom);
        ev.btn_idx  = 2'($urandom);
        ev.btn_down = 1'($urandom);
        return ev;
    endfunction

    // Sends one request, with a random gap at the start of each burst.
    task automatic send_event(input t_mouse_event ev);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            case ($urandom_range(0, 3))
                0:       gap = 0;
                1, 2:    gap = $urandom_range(1, 3);
                default: gap = $urandom_range(4, 15);
            endcase
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid     <= 1'b1;
        i_opcode       <= ev.opcode;
        i_move_x       <= ev.move_x;
        i_move_y       <= ev.move_y;
        i_pos_x        <= ev.pos_x;
        i_pos_y        <= ev.pos_y;
        i_target_cur_x <= ev.tcur_x;
        i_target_cur_y <= ev.tcur_y;
        i_button_index <= ev.btn_idx;
        i_button_down  <= ev.btn_down;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        encode_event(ev);
        n_sent++;
    endtask

    task automatic send_op(input logic [2:0] op);
        send_event(make_event(op));
    endtask

    task automatic send_move(input logic signed [23:0] mx, input logic signed [23:0] my);
        t_mouse_event ev;
        ev = make_event(mpg_pkg::OP_ADD_MOVE);
        ev.move_x = mx;
        ev.move_y = my;
        send_event(ev);
    endtask

    task automatic send_pos(input logic [15:0] px, input logic [15:0] py,
                            input logic [15:0] tx, input logic [15:0] ty);
        t_mouse_event ev;
        ev = make_event(mpg_pkg::OP_SET_POS);
        ev.pos_x  = px;
        ev.pos_y  = py;
        ev.tcur_x = tx;
        ev.tcur_y = ty;
        send_event(ev);
    endtask

    task automatic send_btn(input logic [1:0] idx, input logic down);
        t_mouse_event ev;
        ev = make_event(mpg_pkg::OP_SET_BTN);
        ev.btn_idx  = idx;
        ev.btn_down = down;
        send_event(ev);
    endtask

    task automatic send_init(input logic [15:0] px, input logic [15:0] py);
        t_mouse_event ev;
        ev = make_event(mpg_pkg::OP_INIT);
        ev.pos_x = px;
        ev.pos_y = py;
        send_event(ev);
    endtask

    // Stops offering requests and waits until every reply is back.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (reply_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_mode(input bit m);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= m;
        @(posedge i_clk);
        rel_mode = m;
        i_cfg_we <= 1'b0;
    endtask

    task automatic test_directed_absolute();
        // Before init, movement and position are dropped but buttons still work.
        send_move(24'sh000100, 24'sh000100);
        send_pos(16'h1234, 16'h5678, 16'h0000, 16'h0000);
        send_op(mpg_pkg::OP_REQ_PKT);
        send_btn(mpg_pkg::BTN_LEFT, 1'b1);
        send_op(mpg_pkg::OP_REQ_PKT);
        for (int op = OP_UNUSED_LO; op <= OP_UNUSED_HI; op++)
            send_op(3'(op));
        send_init(16'hFFFF, 16'h0000);
        send_pos(16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000);
        send_op(mpg_pkg::OP_REQ_PKT);
        send_op(mpg_pkg::OP_REQ_PKT);
        send_btn(BTN_SPARE_A, 1'b1);
        send_btn(BTN_SPARE_B, 1'b0);
        send_btn(mpg_pkg::BTN_RIGHT, 1'b1);
        send_btn(mpg_pkg::BTN_LEFT, 1'b0);
        send_op(mpg_pkg::OP_REQ_PKT);
        send_pos(16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_op(mpg_pkg::OP_REQ_PKT);
        send_move(24'sh000080, -24'sh000080);
    endtask

    task automatic test_directed_relative();
        // Half a pixel either way truncates to no motion.
        send_op(mpg_pkg::OP_REQ_PKT);
        send_move(24'sh000080, -24'sh000100);
        send_op(mpg_pkg::OP_REQ_PKT);
        send_op(mpg_pkg::OP_REQ_PKT);
        send_btn(mpg_pkg::BTN_LEFT, 1'b1);
        send_op(mpg_pkg::OP_REQ_PKT);
    endtask

    task automatic test_accumulator_limits();
        repeat (260) send_move(24'sh7FFFFF, 24'sh800000);
        repeat (3) send_op(mpg_pkg::OP_REQ_PKT);
        repeat (256) send_move(24'sh800000, 24'sh7FFFFF);
        repeat (4) send_op(mpg_pkg::OP_REQ_PKT);
    endtask

    task automatic test_backpressure();
        hold_go = 1'b1;
        repeat (30) send_op(3'($urandom_range(0, 4)));
        hold_go = 1'b0;
        wait_idle();
    endtask

    // Mostly well-formed sequences with random content, plus some noise.
    task automatic test_random_traffic(input int n_items);
        int           k;
        int           reps;
        t_mouse_event ev;
        k = 0;
        while (k < n_items) begin
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    reps = $urandom_range(1, 4);
                    repeat (reps) begin
                        send_op(mpg_pkg::OP_ADD_MOVE);
                        k++;
                    end
                    reps = $urandom_range(1, 3);
                    repeat (reps) begin
                        send_op(mpg_pkg::OP_REQ_PKT);
                        k++;
                    end
                end
                3, 4: begin
                    ev = make_event(mpg_pkg::OP_SET_POS);
                    if ($urandom_range(0, 1)) begin
                        ev.tcur_x = 16'(int'(ev.pos_x) + int'($urandom_range(0, 600)) - 300);
                        ev.tcur_y = 16'(int'(ev.pos_y) + int'($urandom_range(0, 600)) - 300);
                    end
                    send_event(ev);
                    k++;
                    reps = $urandom_range(1, 4);
                    repeat (reps) begin
                        send_op(mpg_pkg::OP_REQ_PKT);
                        k++;
                    end
                end
                5, 6: begin
                    send_op(mpg_pkg::OP_SET_BTN);
                    send_op(mpg_pkg::OP_REQ_PKT);
                    k += 2;
                end
                7: begin
                    send_op(mpg_pkg::OP_INIT);
                    k++;
                end
                default: begin
                    send_op(3'($urandom));
                    k++;
                end
            endcase
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        set_mode(1'b0);
        test_directed_absolute();
        set_mode(1'b1);
        test_directed_relative();
        test_accumulator_limits();
        test_backpressure();
        test_random_traffic(180);
        set_mode(1'b0);
        test_random_traffic(180);
        set_mode(1'b1);
        test_random_traffic(160);
        set_mode(1'b0);
        test_backpressure();
        test_random_traffic(160);

        wait_idle();
        repeat (8) @(posedge i_clk);
        if (reply_q.size() != 0)
            report("replies never returned", 32'd0, 32'(reply_q.size()));

        $display("Sent %0d events, checked %0d replies of which %0d carried packets.",
                 n_sent, n_replies, n_packets);
        $display("Both modes, accumulator saturation, clamping, ignored buttons and long stalls.");
        if (errors == 0) begin
            $display("mouse_packet_generator: match");
        end else begin
            $display("%0d errors", errors);
            $display("mouse_packet_generator: mismatch");
        end
        $finish;
    end

endmodule : mouse_packet_generator_tb
